>>> hw/rtl/cpa_pkg.sv
package cpa_pkg;

    // per endpoint line state
    typedef enum logic [1:0] {
        EP_FREE      = 2'd0,
        EP_BUSY      = 2'd1,
        EP_IMPATIENT = 2'd2
    } t_ep_state;

    // input command codes
    localparam logic CMD_CALL = 1'b0;
    localparam logic CMD_HANG = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_ORIGIN_BUSY = 2'd0;
    localparam logic [1:0] STAT_RETRY       = 2'd1;
    localparam logic [1:0] STAT_CONNECTED   = 2'd2;
    localparam logic [1:0] STAT_HUNG_UP     = 2'd3;

    localparam logic [6:0] BUSY_MAX     = 7'd127;
    localparam logic [6:0] ACTIVE_RESET = 7'd64;

    // control handed to each cell of the ring
    typedef struct packed {
        logic      shift;
        logic      wr_en;
        t_ep_state wr_data;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/cpa_cell.sv
module cpa_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpa_pkg::t_cell_ctrl i_ctrl,
    input  cpa_pkg::t_ep_state  i_next,
    output cpa_pkg::t_ep_state  o_state
);

    cpa_pkg::t_ep_state r_state;

    // direct write wins, otherwise take the neighbor's entry when the ring rotates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpa_pkg::EP_FREE;
        end else if (i_ctrl.wr_en) begin
            r_state <= i_ctrl.wr_data;
        end else if (i_ctrl.shift) begin
            r_state <= i_next;
        end
    end

    assign o_state = r_state;

endmodule

>>> hw/rtl/call_pairing_allocator.sv
// flow: an input transfer moves the FSM from idle to scan, the endpoint ring makes
//   one full rotation past the head cell, and the finish state commits the writes
//   and registers the result, waiting while an earlier result still waits in the
//   output register; o_ready is high only in idle, so a new request is taken only
//   after the last one has finished
// reset: synchronous active-low; all endpoints free, busy count zero,
//   active_nodes 64, no result pending
module call_pairing_allocator #(
    parameter int MAX_NODES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: active_nodes
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_command,
    input  logic [5:0] i_origin_id,
    input  logic [5:0] i_callee_id,
    input  logic [5:0] i_free_rank,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [5:0] o_partner_id,
    output logic       o_recall_partner
);

    // ring index width and a compare width that holds ids, counts and active_nodes
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int CW = (NW > 7) ? NW : 7;
    localparam logic [IW-1:0] LAST_PTR = IW'(MAX_NODES - 1);
    localparam logic [CW-1:0] NODES_CW = CW'(MAX_NODES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_fsm;

    t_fsm                r_fsm;
    logic [IW-1:0]       r_ptr;        // logical index sitting in the head cell
    logic [6:0]          r_active_nodes;
    logic [6:0]          r_busy_count;

    // latched request
    logic                r_cmd;
    logic [CW-1:0]       r_origin;
    logic [CW-1:0]       r_callee;
    logic [CW-1:0]       r_rank;

    // scan token collected at the head cell
    logic [CW-1:0]       r_seen;
    logic [CW-1:0]       r_pick;
    logic                r_found;
    logic                r_exact;
    cpa_pkg::t_ep_state  r_org_st;
    cpa_pkg::t_ep_state  r_cal_st;

    // output register
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [5:0]          r_partner;
    logic                r_recall;

    cpa_pkg::t_ep_state  w_cell_state [MAX_NODES];
    cpa_pkg::t_cell_ctrl w_cell_ctrl  [MAX_NODES];

    logic [CW-1:0]       w_n;          // active_nodes clamped to 2..MAX_NODES
    logic [CW-1:0]       w_active_ext;
    logic [CW-1:0]       w_ptr_ext;
    cpa_pkg::t_ep_state  w_head;
    logic                w_elig;
    logic                w_go;

    // decision made in the finish cycle
    logic                w_origin_ok;
    logic                w_callee_ok;
    logic                w_room;
    logic                w_wa_en;
    logic                w_wb_en;
    cpa_pkg::t_ep_state  w_wa_data;
    cpa_pkg::t_ep_state  w_wb_data;
    logic [CW-1:0]       w_wb_idx;
    logic [1:0]          w_status;
    logic [5:0]          w_partner;
    logic                w_recall;
    logic [6:0]          n_busy_count;

    always_comb begin
        w_active_ext = CW'(r_active_nodes);
        if (w_active_ext < CW'(2)) begin
            w_n = CW'(2);
        end else if (w_active_ext > NODES_CW) begin
            w_n = NODES_CW;
        end else begin
            w_n = w_active_ext;
        end
    end

    // head cell: cell 0 holds logical index r_ptr during the rotation
    assign w_head    = w_cell_state[0];
    assign w_ptr_ext = CW'(r_ptr);
    assign w_elig    = (w_ptr_ext < w_n) && (w_ptr_ext != r_origin)
                       && (w_head == cpa_pkg::EP_FREE);

    // finish only when the output register is free or being emptied
    assign w_go = (r_fsm == S_FINISH) && (!r_out_valid || i_ready);

    always_comb begin
        w_origin_ok  = r_origin < NODES_CW;
        w_callee_ok  = r_callee < NODES_CW;
        // free count is n - 1 - busy; a partner needs it above zero
        w_room       = ({1'b0, CW'(r_busy_count)} + (CW + 1)'(1)) < {1'b0, w_n};
        w_wa_en      = 1'b0;
        w_wb_en      = 1'b0;
        w_wa_data    = cpa_pkg::EP_FREE;
        w_wb_data    = cpa_pkg::EP_FREE;
        w_wb_idx     = r_callee;
        w_status     = cpa_pkg::STAT_RETRY;
        w_partner    = 6'd0;
        w_recall     = 1'b0;
        n_busy_count = r_busy_count;
        if (r_cmd == cpa_pkg::CMD_CALL) begin
            if (!w_origin_ok) begin
                w_status = cpa_pkg::STAT_RETRY;
            end else if (r_org_st != cpa_pkg::EP_FREE) begin
                // caller already in a call: mark it impatient
                w_status  = cpa_pkg::STAT_ORIGIN_BUSY;
                w_wa_en   = 1'b1;
                w_wa_data = cpa_pkg::EP_IMPATIENT;
            end else if (!w_room || !r_found) begin
                w_status = cpa_pkg::STAT_RETRY;
            end else begin
                w_status  = cpa_pkg::STAT_CONNECTED;
                w_partner = r_pick[5:0];
                w_wa_en   = 1'b1;
                w_wa_data = cpa_pkg::EP_BUSY;
                w_wb_en   = 1'b1;
                w_wb_data = cpa_pkg::EP_BUSY;
                w_wb_idx  = r_pick;
                n_busy_count = (r_busy_count >= (cpa_pkg::BUSY_MAX - 7'd1))
                               ? cpa_pkg::BUSY_MAX : r_busy_count + 7'd2;
            end
        end else begin
            // hang-up: origin and callee are freed, and a self hang-up never recalls
            w_status = cpa_pkg::STAT_HUNG_UP;
            w_wa_en  = w_origin_ok;
            w_wb_en  = w_callee_ok;
            w_recall = w_callee_ok && (r_callee != r_origin)
                       && (r_cal_st == cpa_pkg::EP_IMPATIENT);
            n_busy_count = (r_busy_count >= 7'd2) ? r_busy_count - 7'd2 : 7'd0;
        end
    end

    // ring of endpoint cells, each passing its entry to the lower neighbor
    for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
        logic w_hit_a;
        logic w_hit_b;

        assign w_hit_a = w_wa_en && (r_origin == CW'(k));
        assign w_hit_b = w_wb_en && (w_wb_idx == CW'(k));

        assign w_cell_ctrl[k].shift   = (r_fsm == S_SCAN);
        assign w_cell_ctrl[k].wr_en   = w_go && (w_hit_a || w_hit_b);
        assign w_cell_ctrl[k].wr_data = w_hit_a ? w_wa_data : w_wb_data;

        cpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_cell_ctrl[k]),
            .i_next  (w_cell_state[(k + 1) % MAX_NODES]),
            .o_state (w_cell_state[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm          <= S_IDLE;
            r_ptr          <= '0;
            r_active_nodes <= cpa_pkg::ACTIVE_RESET;
            r_busy_count   <= 7'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_nodes <= i_cfg_data;
            end
            // result transfer empties the output register unless a new result lands
            if (r_out_valid && i_ready && !w_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_command;
                        r_origin <= CW'(i_origin_id);
                        r_callee <= CW'(i_callee_id);
                        r_rank   <= CW'(i_free_rank);
                        r_seen   <= '0;
                        r_pick   <= '0;
                        r_found  <= 1'b0;
                        r_exact  <= 1'b0;
                        r_ptr    <= '0;
                        r_fsm    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // rank search: keep the latest free entry until the exact rank hits
                    if (w_elig) begin
                        r_seen <= r_seen + CW'(1);
                        if (!r_exact) begin
                            r_pick  <= w_ptr_ext;
                            r_found <= 1'b1;
                            if (r_seen == r_rank) begin
                                r_exact <= 1'b1;
                            end
                        end
                    end
                    if (w_ptr_ext == r_origin) begin
                        r_org_st <= w_head;
                    end
                    if (w_ptr_ext == r_callee) begin
                        r_cal_st <= w_head;
                    end
                    // after a full rotation every cell is back at its own index
                    if (r_ptr == LAST_PTR) begin
                        r_ptr <= '0;
                        r_fsm <= S_FINISH;
                    end else begin
                        r_ptr <= r_ptr + IW'(1);
                    end
                end
                S_FINISH: begin
                    if (w_go) begin
                        r_busy_count <= n_busy_count;
                        r_status     <= w_status;
                        r_partner    <= w_partner;
                        r_recall     <= w_recall;
                        r_out_valid  <= 1'b1;
                        r_fsm        <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_fsm == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_partner_id     = r_partner;
    assign o_recall_partner = r_recall;

endmodule

>>> hw/rtl/cpa_checker.sv
module cpa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic [5:0] o_partner_id,
    input logic       o_recall_partner
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
                                   && $stable(o_partner_id) && $stable(o_recall_partner)))
        else $error("result changed while stalled");

    // one item in flight: ready drops right after an input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in flight");

    // recall only reported by a hang-up
    a_recall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_recall_partner) |-> (o_status == cpa_pkg::STAT_HUNG_UP))
        else $error("recall without hang-up");

    // partner is zero unless connected
    a_partner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cpa_pkg::STAT_CONNECTED)) |-> (o_partner_id == 6'd0))
        else $error("partner set without connect");

endmodule

bind call_pairing_allocator cpa_checker u_cpa_checker (.*);
